>>> hw/rtl/tscs_pkg.sv
package tscs_pkg;

	typedef enum logic [1:0] {
		KIND_LAY   = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IGNORED = 3'd0,
		ST_ADDED   = 3'd1,
		ST_CLOSE   = 3'd2,
		ST_OPENED  = 3'd3,
		ST_NOFREE  = 3'd4,
		ST_TICK    = 3'd5
	} status_t;

	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_SPACING = 2'd1;
	localparam logic [1:0] REG_LIFE    = 2'd2;
	localparam logic [1:0] REG_MAX     = 2'd3;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_DECODE,
		CMD_DIST,
		CMD_SUM,
		CMD_APPEND,
		CMD_TICK_INIT,
		CMD_TICK_RD,
		CMD_TICK_WR,
		CMD_TICK_CHAIN,
		CMD_RESULT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
	} cmd_t;

	typedef struct packed {
		logic    do_append;
		logic    is_tick;
		logic    tick_chain_done;
		logic    tick_all_done;
		logic    tick_sample_last;
	} stat_t;

endpackage

>>> hw/rtl/tscs_ctrl.sv
module tscs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tscs_pkg::stat_t stat,
	output tscs_pkg::cmd_t  cmd
);
	import tscs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_DIST, S_SUM, S_APPEND,
		S_TINIT, S_TRD, S_TWR, S_TCHAIN, S_RESULT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (start) state_q <= S_DECODE;
				S_DECODE: state_q <= stat.is_tick ? S_TINIT : S_DIST;
				S_DIST:   state_q <= S_SUM;
				S_SUM:    state_q <= stat.do_append ? S_APPEND : S_RESULT;
				S_APPEND: state_q <= S_RESULT;
				S_TINIT: begin
					if (stat.tick_all_done) state_q <= S_RESULT;
					else if (stat.tick_chain_done) state_q <= S_TCHAIN;
					else state_q <= S_TRD;
				end
				S_TRD:    state_q <= S_TWR;
				S_TWR:    state_q <= stat.tick_sample_last ? S_TCHAIN : S_TRD;
				S_TCHAIN: state_q <= stat.tick_all_done ? S_RESULT : S_TINIT;
				S_RESULT: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		unique case (state_q)
			S_IDLE:   cmd.op = start ? CMD_DECODE : CMD_NONE;
			S_DECODE: cmd.op = CMD_DIST;
			S_DIST:   cmd.op = CMD_SUM;
			S_SUM:    cmd.op = CMD_NONE;
			S_APPEND: cmd.op = CMD_APPEND;
			S_TINIT:  cmd.op = CMD_TICK_INIT;
			S_TRD:    cmd.op = CMD_TICK_RD;
			S_TWR:    cmd.op = CMD_TICK_WR;
			S_TCHAIN: cmd.op = CMD_TICK_CHAIN;
			S_RESULT: cmd.op = CMD_RESULT;
			default:  cmd.op = CMD_NONE;
		endcase
	end

`ifndef SYNTHESIS
	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (state_q == S_DECODE))
		else $error("start not taken");
	a_result_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) |=> (state_q == S_IDLE))
		else $error("result not followed by idle");
	a_append_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPEND) |=> (state_q == S_RESULT))
		else $error("append not followed by result");
`endif

endmodule

>>> hw/rtl/tscs_dp.sv
module tscs_dp #(
	parameter int CHAINS   = 16,
	parameter int SAMPLES  = 64,
	parameter int POS_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tscs_pkg::cmd_t        cmd,
	output tscs_pkg::stat_t       stat,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic [1:0]            kind,
	input  logic [4:0]            chain_id,
	input  logic [POS_BITS-1:0]   pos_x,
	input  logic [POS_BITS-1:0]   pos_y,
	input  logic [POS_BITS-1:0]   pos_z,
	input  logic [15:0]           tick_ms,
	output logic                  done,
	output logic [4:0]            result_chain,
	output logic [2:0]            status,
	output logic [10:0]           live_samples,
	output logic [4:0]            live_chains,
	output logic [31:0]           laid_total,
	output logic [31:0]           discarded_total,
	output logic [10:0]           expired_now
);
	import tscs_pkg::*;

	localparam int CW   = (CHAINS > 1) ? $clog2(CHAINS) : 1;
	localparam int SW   = $clog2(SAMPLES);
	localparam int NW   = $clog2(SAMPLES + 1);
	localparam int AW   = $clog2(CHAINS * SAMPLES);
	localparam int DW   = POS_BITS + 1;
	localparam int PW   = 3 * POS_BITS;
	localparam logic [4:0] NO_CHAIN = 5'd16;

	logic          enable_q;
	logic [15:0]   spacing_q;
	logic [15:0]   life_q;
	logic [6:0]    max_q;

	logic [CHAINS-1:0] in_use_q;
	logic [CHAINS-1:0] open_q;
	logic [SW-1:0]     head_q  [CHAINS];
	logic [NW-1:0]     count_q [CHAINS];
	logic [PW-1:0]     last_q  [CHAINS];
	logic [15:0]       age_mem [CHAINS*SAMPLES];

	logic [10:0] live_q;
	logic [31:0] laid_q;
	logic [31:0] disc_q;
	logic [4:0]  chains_live_q;
	logic [10:0] expired_q;

	logic [1:0]           kind_q;
	logic [PW-1:0]        pos_q;
	logic [15:0]          dt_q;
	logic [CW-1:0]        ch_q;
	logic [2:0]           st_q;
	logic [4:0]           rc_q;
	logic                 app_q;
	logic                 open_new_q;
	logic                 close_q;
	logic [2*DW-1:0]      sq_q [3];
	logic [CW:0]          tc_q;
	logic [NW-1:0]        ti_q;
	logic [NW-1:0]        cut_q;
	logic                 front_q;
	logic [15:0]          age_rd_q;
	logic [AW-1:0]        addr_q;

	logic [NW-1:0] cap;
	always_comb begin
		if (max_q < 7'd2) cap = NW'(2);
		else if (32'(max_q) > 32'(SAMPLES)) cap = NW'(SAMPLES);
		else cap = NW'(max_q);
	end

	logic [CW-1:0] free_c;
	logic          free_ok;
	always_comb begin
		free_c  = '0;
		free_ok = 1'b0;
		for (int c = CHAINS - 1; c >= 0; c--) begin
			if (!in_use_q[c]) begin
				free_c  = CW'(c);
				free_ok = 1'b1;
			end
		end
	end

	logic          id_ok;
	logic [CW-1:0] id_c;
	assign id_ok = (32'(chain_id) < 32'(CHAINS));
	assign id_c  = CW'(chain_id);

	logic [DW-1:0] dif [3];
	logic [DW-1:0] mag [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dif[k] = DW'($signed(pos_q[k*POS_BITS +: POS_BITS]))
				- DW'($signed(last_q[ch_q][k*POS_BITS +: POS_BITS]));
			mag[k] = dif[k][DW-1] ? (~dif[k] + 1'b1) : dif[k];
		end
	end

	logic [2*DW+1:0] dsum;
	logic [31:0]     lim;
	assign dsum = (2*DW+2)'(sq_q[0]) + (2*DW+2)'(sq_q[1]) + (2*DW+2)'(sq_q[2]);
	assign lim  = spacing_q * spacing_q;

	logic [NW-1:0] cnt_c;
	logic [SW-1:0] head_c;
	logic          full_c;
	assign cnt_c  = count_q[ch_q];
	assign head_c = head_q[ch_q];
	assign full_c = open_new_q ? 1'b0 : (cnt_c >= cap);

	logic [CW-1:0] tch;
	assign tch = tc_q[CW-1:0];
	logic [16:0] aged;
	assign aged = 17'(age_rd_q) + 17'(dt_q);
	logic [15:0] aged_sat;
	assign aged_sat = aged[16] ? 16'hFFFF : aged[15:0];

	logic [SW-1:0] slot;
	assign slot = head_q[tch] + SW'(ti_q);
	logic [NW-1:0] tcnt_left;
	assign tcnt_left = count_q[tch] - cut_q;

	assign stat.do_append       = app_q;
	assign stat.is_tick         = (kind_q == KIND_TICK) && enable_q;
	assign stat.tick_all_done   = (32'(tc_q) >= 32'(CHAINS));
	assign stat.tick_chain_done = !in_use_q[tch] || (count_q[tch] == '0);
	assign stat.tick_sample_last = (ti_q + 1'b1 >= count_q[tch]);

	logic [AW-1:0] app_addr;
	logic [SW-1:0] app_head;
	logic [NW-1:0] app_cnt;
	always_comb begin
		app_head = open_new_q ? '0 : head_c;
		app_cnt  = open_new_q ? '0 : cnt_c;
		if (full_c) begin
			app_head = head_c + 1'b1;
			app_cnt  = cnt_c - 1'b1;
		end
		app_addr = AW'(ch_q) * AW'(SAMPLES) + AW'(SW'(app_head + SW'(app_cnt)));
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_APPEND) age_mem[app_addr] <= '0;
		else if (cmd.op == CMD_TICK_WR) age_mem[addr_q] <= aged_sat;
		if (cmd.op == CMD_TICK_RD) age_rd_q <= age_mem[AW'(tch) * AW'(SAMPLES) + AW'(slot)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			spacing_q     <= 16'd100;
			life_q        <= 16'd4000;
			max_q         <= 7'd64;
			in_use_q      <= '0;
			open_q        <= '0;
			live_q        <= '0;
			laid_q        <= '0;
			disc_q        <= '0;
			chains_live_q <= '0;
			done          <= 1'b0;
			app_q         <= 1'b0;
			for (int c = 0; c < CHAINS; c++) begin
				head_q[c]  <= '0;
				count_q[c] <= '0;
			end
		end else begin
			done <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_ENABLE:  enable_q  <= cfg_data[0];
					REG_SPACING: spacing_q <= cfg_data;
					REG_LIFE:    life_q    <= cfg_data;
					REG_MAX:     max_q     <= cfg_data[6:0];
					default:     ;
				endcase
			end
			unique case (cmd.op)
				CMD_DECODE: begin
					kind_q     <= kind;
					pos_q      <= {pos_z, pos_y, pos_x};
					dt_q       <= tick_ms;
					expired_q  <= '0;
					tc_q       <= '0;
					ti_q       <= '0;
					cut_q      <= '0;
					front_q    <= 1'b1;
					app_q      <= 1'b0;
					open_new_q <= 1'b0;
					close_q    <= 1'b0;
					ch_q       <= id_c;
					rc_q       <= NO_CHAIN;
					st_q       <= ST_IGNORED;
					if (!enable_q) begin
					end else if (kind == KIND_LAY) begin
						if (!id_ok || !open_q[id_c]) begin
							if (!free_ok) st_q <= ST_NOFREE;
							else begin
								ch_q       <= free_c;
								rc_q       <= 5'(free_c);
								st_q       <= ST_OPENED;
								open_new_q <= 1'b1;
								app_q      <= 1'b1;
							end
						end else begin
							rc_q <= chain_id;
							st_q <= ST_ADDED;
						end
					end else if (kind == KIND_CLOSE) begin
						if (id_ok && in_use_q[id_c]) begin
							rc_q    <= chain_id;
							st_q    <= ST_ADDED;
							app_q   <= 1'b1;
							close_q <= 1'b1;
						end
					end else if (kind == KIND_TICK) begin
						st_q <= ST_TICK;
					end
				end
				CMD_DIST: begin
					for (int k = 0; k < 3; k++) sq_q[k] <= mag[k] * mag[k];
				end
				CMD_SUM: begin
					if (enable_q && kind_q == KIND_LAY && st_q == ST_ADDED && !open_new_q) begin
						if (dsum < (2*DW+2)'(lim)) st_q <= ST_CLOSE;
						else app_q <= 1'b1;
					end
				end
				CMD_APPEND: begin
					if (open_new_q) begin
						in_use_q[ch_q] <= 1'b1;
						open_q[ch_q]   <= 1'b1;
					end
					if (close_q) open_q[ch_q] <= 1'b0;
					head_q[ch_q]  <= app_head;
					count_q[ch_q] <= app_cnt + 1'b1;
					last_q[ch_q]  <= pos_q;
					laid_q        <= laid_q + 1'b1;
					if (full_c) disc_q <= disc_q + 1'b1;
					else live_q <= live_q + 1'b1;
				end
				CMD_TICK_INIT: begin
					if (tc_q == '0) chains_live_q <= '0;
					ti_q    <= '0;
					cut_q   <= '0;
					front_q <= 1'b1;
				end
				CMD_TICK_RD: begin
					addr_q <= AW'(tch) * AW'(SAMPLES) + AW'(slot);
				end
				CMD_TICK_WR: begin
					if (front_q && aged_sat >= life_q) cut_q <= cut_q + 1'b1;
					else front_q <= 1'b0;
					ti_q <= ti_q + 1'b1;
				end
				CMD_TICK_CHAIN: begin
					if (in_use_q[tch]) begin
						head_q[tch]  <= head_q[tch] + SW'(cut_q);
						count_q[tch] <= tcnt_left;
						live_q       <= live_q - 11'(cut_q);
						expired_q    <= expired_q + 11'(cut_q);
						if (tcnt_left == '0 && !open_q[tch]) in_use_q[tch] <= 1'b0;
						else if (tcnt_left != '0) chains_live_q <= chains_live_q + 1'b1;
					end
					tc_q <= tc_q + 1'b1;
				end
				CMD_RESULT: begin
					done <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign result_chain    = rc_q;
	assign status          = st_q;
	assign live_samples    = live_q;
	assign live_chains     = chains_live_q;
	assign laid_total      = laid_q;
	assign discarded_total = disc_q;
	assign expired_now     = expired_q;

`ifndef SYNTHESIS
	a_open_implies_use: assert property (@(posedge clk) disable iff (!arst_n)
		(open_q & ~in_use_q) == '0)
		else $error("open chain not in use");
	a_laid_on_append: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_APPEND) |=> (laid_q == $past(laid_q) + 32'd1))
		else $error("laid count did not advance");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
`endif

endmodule

>>> hw/rtl/trail_sample_chain_store_top.sv
// Channel  Signals                                   Direction
// request  start, busy, kind..tick_ms                in, busy out
// result   done, result_chain..expired_now           out
// config   cfg_valid, cfg_ready, cfg_index, cfg_data in, cfg_ready out
// A lay or close steps through decode, square, compare and result, plus an append
// step when a point is stored; done rises in the same cycle that busy drops.
// A tick walks each chain: init, a read-modify-write of each stored age entry,
// then a chain update; it ends with result.
// Reset is asynchronous; no clearing pass is needed.
// Results cannot be stalled; each shows for one cycle with done.
module trail_sample_chain_store_top #(
	parameter int CHAINS   = 16,
	parameter int SAMPLES  = 64,
	parameter int POS_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [4:0]          chain_id,
	input  logic [POS_BITS-1:0] pos_x,
	input  logic [POS_BITS-1:0] pos_y,
	input  logic [POS_BITS-1:0] pos_z,
	input  logic [15:0]         tick_ms,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                done,
	output logic [4:0]          result_chain,
	output logic [2:0]          status,
	output logic [10:0]         live_samples,
	output logic [4:0]          live_chains,
	output logic [31:0]         laid_total,
	output logic [31:0]         discarded_total,
	output logic [10:0]         expired_now
);
	import tscs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	tscs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	tscs_dp #(
		.CHAINS   (CHAINS),
		.SAMPLES  (SAMPLES),
		.POS_BITS (POS_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.kind            (kind),
		.chain_id        (chain_id),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.tick_ms         (tick_ms),
		.done            (done),
		.result_chain    (result_chain),
		.status          (status),
		.live_samples    (live_samples),
		.live_chains     (live_chains),
		.laid_total      (laid_total),
		.discarded_total (discarded_total),
		.expired_now     (expired_now)
	);

endmodule

>>> tb/trail_store_checker.sv
`timescale 1ns / 1ps

module trail_store_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [4:0]  chain_id,
	input  logic [23:0] pos_x,
	input  logic [23:0] pos_y,
	input  logic [23:0] pos_z,
	input  logic [15:0] tick_ms,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        done,
	input  logic [4:0]  result_chain,
	input  logic [2:0]  status,
	input  logic [10:0] live_samples,
	input  logic [4:0]  live_chains,
	input  logic [31:0] laid_total,
	input  logic [31:0] discarded_total,
	input  logic [10:0] expired_now,
	output int          pending,
	output int          fails
);
	import tscs_pkg::*;

	localparam int NCH = 16;
	localparam int NSMP = 64;
	localparam logic [4:0] NO_CHAIN = 5'd16;

	typedef struct packed {
		logic [4:0]  chain;
		logic [2:0]  st;
		logic [10:0] live;
		logic [4:0]  chains;
		logic [31:0] laid;
		logic [31:0] disc;
		logic [10:0] expired;
	} outcome_t;

	outcome_t outcomes_due[$];

	logic        en_r;
	logic [15:0] spacing_r;
	logic [15:0] life_r;
	logic [6:0]  max_r;

	logic        in_use[NCH];
	logic        is_open[NCH];
	longint      last_p[NCH][3];
	int          head[NCH];
	int          cnt[NCH];
	logic [15:0] ages[NCH][NSMP];
	logic [10:0] live_n;
	logic [31:0] laid_n;
	logic [31:0] disc_n;
	logic [4:0]  chains_n;

	initial begin
		fails = 0;
		en_r = 1'b1;
		spacing_r = 16'd100;
		life_r = 16'd4000;
		max_r = 7'd64;
		live_n = '0;
		laid_n = '0;
		disc_n = '0;
		chains_n = '0;
		for (int c = 0; c < NCH; c++) begin
			in_use[c] = 1'b0;
			is_open[c] = 1'b0;
			head[c] = 0;
			cnt[c] = 0;
		end
	end

	assign pending = outcomes_due.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	task automatic append_point(input int c, input longint p[3]);
		int cap;
		cap = (max_r < 2) ? 2 : (max_r > NSMP) ? NSMP : int'(max_r);
		if (cnt[c] >= cap) begin
			head[c] = (head[c] + 1) % NSMP;
			cnt[c]--;
			disc_n++;
			live_n--;
		end
		ages[c][(head[c] + cnt[c]) % NSMP] = '0;
		last_p[c] = p;
		cnt[c]++;
		live_n++;
		laid_n++;
	endtask

	task automatic age_all(input logic [15:0] dt, output logic [10:0] gone);
		int cut;
		logic front;
		logic [16:0] a;
		gone = '0;
		chains_n = '0;
		for (int c = 0; c < NCH; c++) begin
			if (in_use[c]) begin
				cut = 0;
				front = 1'b1;
				for (int i = 0; i < cnt[c]; i++) begin
					a = ages[c][(head[c] + i) % NSMP] + dt;
					if (a > 17'd65535) a = 17'd65535;
					ages[c][(head[c] + i) % NSMP] = a[15:0];
					if (front && a[15:0] >= life_r) cut++;
					else front = 1'b0;
				end
				head[c] = (head[c] + cut) % NSMP;
				cnt[c] -= cut;
				live_n -= cut;
				gone += cut;
				if (cnt[c] == 0 && !is_open[c]) in_use[c] = 1'b0;
				else if (cnt[c] > 0) chains_n++;
			end
		end
	endtask

	task automatic predict_request();
		outcome_t o;
		longint p[3];
		longint unsigned d2, lim, m;
		int id, c;
		id = chain_id;
		p[0] = longint'(signed'(pos_x));
		p[1] = longint'(signed'(pos_y));
		p[2] = longint'(signed'(pos_z));
		o.chain = NO_CHAIN;
		o.st = ST_IGNORED;
		o.expired = '0;
		if (en_r) begin
			case (kind_t'(kind))
				KIND_LAY: begin
					if (id >= NCH || !is_open[id]) begin
						c = 0;
						while (c < NCH && in_use[c]) c++;
						if (c >= NCH) begin
							o.st = ST_NOFREE;
						end else begin
							in_use[c] = 1'b1;
							is_open[c] = 1'b1;
							head[c] = 0;
							cnt[c] = 0;
							append_point(c, p);
							o.chain = c[4:0];
							o.st = ST_OPENED;
						end
					end else begin
						lim = longint'(spacing_r) * longint'(spacing_r);
						d2 = 0;
						for (int k = 0; k < 3; k++) begin
							m = (last_p[id][k] > p[k]) ? last_p[id][k] - p[k] : p[k] - last_p[id][k];
							d2 += m * m;
						end
						o.chain = id[4:0];
						if (d2 < lim) begin
							o.st = ST_CLOSE;
						end else begin
							append_point(id, p);
							o.st = ST_ADDED;
						end
					end
				end
				KIND_CLOSE: begin
					if (id < NCH && in_use[id]) begin
						append_point(id, p);
						is_open[id] = 1'b0;
						o.chain = id[4:0];
						o.st = ST_ADDED;
					end
				end
				KIND_TICK: begin
					age_all(tick_ms, o.expired);
					o.st = ST_TICK;
				end
				default: ;
			endcase
		end
		o.live = live_n;
		o.chains = chains_n;
		o.laid = laid_n;
		o.disc = disc_n;
		outcomes_due.push_back(o);
	endtask

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n) begin
			if (done) begin
				if (outcomes_due.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					w = outcomes_due.pop_front();
					if (result_chain !== w.chain) report("result_chain", result_chain, w.chain);
					if (status !== w.st) report("status", status, w.st);
					if (live_samples !== w.live) report("live_samples", live_samples, w.live);
					if (live_chains !== w.chains) report("live_chains", live_chains, w.chains);
					if (laid_total !== w.laid) report("laid_total", laid_total, w.laid);
					if (discarded_total !== w.disc) report("discarded_total", discarded_total, w.disc);
					if (expired_now !== w.expired) report("expired_now", expired_now, w.expired);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENABLE: en_r = cfg_data[0];
					REG_SPACING: spacing_r = cfg_data;
					REG_LIFE: life_r = cfg_data;
					REG_MAX: max_r = cfg_data[6:0];
					default: ;
				endcase
			end
			if (start && !busy) predict_request();
		end
	end

endmodule

>>> tb/tb_trail_sample_chain_store_top.sv
`timescale 1ns / 1ps

module tb_trail_sample_chain_store_top;
	import tscs_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  kind = KIND_NONE;
	logic [4:0]  chain_id = '0;
	logic [23:0] pos_x = '0;
	logic [23:0] pos_y = '0;
	logic [23:0] pos_z = '0;
	logic [15:0] tick_ms = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        done;
	logic [4:0]  result_chain;
	logic [2:0]  status;
	logic [10:0] live_samples;
	logic [4:0]  live_chains;
	logic [31:0] laid_total;
	logic [31:0] discarded_total;
	logic [10:0] expired_now;
	int          pending;
	int          fails;
	int          quiet_cycles = 0;
	logic [23:0] cursor[17][3];

	always #5 clk = ~clk;

	trail_sample_chain_store_top dut (.*);

	trail_store_checker u_checker (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_request(input kind_t k, input int id, input logic [23:0] x,
		input logic [23:0] y, input logic [23:0] z, input logic [15:0] t);
		start <= 1'b1;
		kind <= k;
		chain_id <= id[4:0];
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		tick_ms <= t;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(20, 200);
		if ($urandom_range(0, 2) == 0) n = 0;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_request();
		int r, id, step;
		kind_t k;
		logic [23:0] p[3];
		r = $urandom_range(0, 99);
		k = (r < 55) ? KIND_LAY : (r < 70) ? KIND_CLOSE : (r < 95) ? KIND_TICK : KIND_NONE;
		id = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(0, 3 + $urandom_range(0, 12));
		step = ($urandom_range(0, 1) == 0) ? 120 : 4000;
		for (int a = 0; a < 3; a++) begin
			if ($urandom_range(0, 9) == 0) p[a] = 24'($urandom);
			else p[a] = cursor[id][a] + 24'($signed($urandom_range(0, 2 * step)) - step);
			cursor[id][a] = p[a];
		end
		send_request(k, id, p[0], p[1], p[2],
			($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500)));
	endtask

	initial begin
		for (int i = 0; i < 17; i++)
			for (int a = 0; a < 3; a++) cursor[i][a] = 24'($urandom);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(KIND_LAY, 16, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0);
		send_request(KIND_LAY, 0, 24'h800000, 24'h800000, 24'h800000, 16'hFFFF);
		send_request(KIND_LAY, 0, 24'h800010, 24'h800000, 24'h800000, 16'h0);
		send_request(KIND_CLOSE, 0, 24'h000000, 24'hFFFFFF, 24'h0, 16'h0);
		send_request(KIND_CLOSE, 0, 24'h000001, 24'h0, 24'h0, 16'h0);
		send_request(KIND_CLOSE, 16, 24'h0, 24'h0, 24'h0, 16'h0);
		send_request(KIND_CLOSE, 5, 24'h0, 24'h0, 24'h0, 16'h0);
		send_request(KIND_NONE, 1, 24'h0, 24'h0, 24'h0, 16'h0);
		for (int i = 0; i < 16; i++) send_request(KIND_LAY, 16, 24'(i), 24'h0, 24'h0, 16'h0);
		send_request(KIND_TICK, 16, 24'h0, 24'h0, 24'h0, 16'h0);
		send_request(KIND_TICK, 16, 24'h0, 24'h0, 24'h0, 16'hFFFF);
		drain();

		write_reg(REG_ENABLE, 16'h0);
		send_request(KIND_LAY, 16, 24'h0, 24'h0, 24'h0, 16'h0);
		send_request(KIND_TICK, 16, 24'h0, 24'h0, 24'h0, 16'h10);
		drain();
		write_reg(REG_ENABLE, 16'hFFFF);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_SPACING, 16'd0);
					write_reg(REG_LIFE, 16'd1);
					write_reg(REG_MAX, 16'd2);
				end
				1: begin
					write_reg(REG_SPACING, 16'hFFFF);
					write_reg(REG_LIFE, 16'hFFFF);
					write_reg(REG_MAX, 16'h007F);
				end
				2: begin
					write_reg(REG_SPACING, 16'd30);
					write_reg(REG_LIFE, 16'd500);
					write_reg(REG_MAX, 16'd0);
				end
				3: begin
					write_reg(REG_SPACING, 16'd200);
					write_reg(REG_LIFE, 16'd2000);
					write_reg(REG_MAX, 16'd5);
				end
				4: begin
					write_reg(REG_SPACING, 16'd1);
					write_reg(REG_LIFE, 16'hFFFF);
					write_reg(REG_MAX, 16'd64);
				end
				default: begin
					write_reg(REG_SPACING, 16'd100);
					write_reg(REG_LIFE, 16'd4000);
					write_reg(REG_MAX, 16'd3);
				end
			endcase
			for (int n = 0; n < 92; n++) begin
				random_request();
				idle_gap();
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
